>>> hdl/dcff_pkg.sv
package dcff_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_REF_CODE  = 3'd5;

  localparam logic [7:0] STOP_BYTE_RST    = 8'hFF;
  localparam logic [7:0] START_CODE_RST   = 8'h01;
  localparam logic [7:0] STOP_CODE_RST    = 8'h02;
  localparam logic [7:0] SET_REF_CODE_RST = 8'h03;

  localparam logic signed [7:0] MS_STOPPED = 8'sd0;
  localparam logic signed [7:0] MS_RUNNING = 8'sd3;

  localparam logic [15:0] REF_DIV = 16'hFFFF;
  localparam logic [15:0] REF_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [15:0] compare_start;
    logic [7:0]  stop_byte;
    logic [7:0]  start_code;
    logic [7:0]  stop_code;
    logic [7:0]  set_ref_code;
  } cfg_t;

  // frame descriptor handed from front to back
  typedef struct packed {
    logic        err;
    logic        bank;
    logic        st;
    logic        sp;
    logic        upd;
    logic [15:0] param;
  } desc_t;

  // bank release from back to front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

>>> hdl/dcff_frame_ram.sv
module dcff_frame_ram #(
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/dcff_desc_fifo.sv
module dcff_desc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dcff_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output dcff_pkg::desc_t desc_o
);
  import dcff_pkg::*;

  desc_t      entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign desc_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = ~wptr_q;
    end
    if (do_pop) begin
      rptr_d = ~rptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule

>>> hdl/dcff_front.sv
module dcff_front #(
  parameter int unsigned FRAME_BYTES = dcff_pkg::FRAME_BYTES_DEF,
  localparam int unsigned CW = $clog2(FRAME_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcff_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic signed [7:0] motor_state_i,
  output logic              push_o,
  output dcff_pkg::desc_t   desc_o,
  input  logic              full_i,
  input  dcff_pkg::rel_t    rel_i,
  output logic              ram_we_o,
  output logic [CW:0]       ram_waddr_o,
  output logic [7:0]        ram_wdata_o
);
  import dcff_pkg::*;

  localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          resync_q, resync_d;
  logic          wbank_q, wbank_d;
  logic [1:0]    busy_q, busy_d;
  logic [7:0]    cmd_q, hi_q, lo_q;

  logic          accept, wr, done, good;
  logic [15:0]   param;
  logic          st, sp, upd;

  assign in_stall_o  = full_i || (!resync_q && busy_q[wbank_q]);
  assign accept      = in_valid_i && !in_stall_o;
  assign wr          = accept && !resync_q;
  assign done        = wr && (cnt_q == LAST_IDX);
  assign good        = (rx_byte_i == cfg_i.stop_byte);
  assign param       = {hi_q, lo_q};

  assign ram_we_o    = wr;
  assign ram_waddr_o = {wbank_q, cnt_q};
  assign ram_wdata_o = rx_byte_i;

  // command decode, start code has priority over stop and set-reference
  always_comb begin
    st  = 1'b0;
    sp  = 1'b0;
    upd = 1'b0;
    if (cmd_q == cfg_i.start_code) begin
      st = 1'b1;
    end else if (cmd_q == cfg_i.stop_code) begin
      sp = 1'b1;
    end else if (cmd_q == cfg_i.set_ref_code) begin
      if (param == 16'd0) begin
        sp = 1'b1;
      end else if (motor_state_i == MS_RUNNING) begin
        upd = 1'b1;
      end else if (motor_state_i == MS_STOPPED) begin
        st = 1'b1;
      end
    end
  end

  assign push_o       = done;
  assign desc_o.err   = !good;
  assign desc_o.bank  = wbank_q;
  assign desc_o.st    = good && st;
  assign desc_o.sp    = good && sp;
  assign desc_o.upd   = good && upd;
  assign desc_o.param = param;

  always_comb begin
    cnt_d    = cnt_q;
    resync_d = resync_q;
    wbank_d  = wbank_q;
    busy_d   = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept && resync_q) begin
      if (good) begin
        resync_d = 1'b0;
      end
    end else if (wr) begin
      if (done) begin
        cnt_d = '0;
        if (good) begin
          busy_d[wbank_q] = 1'b1;
          wbank_d         = ~wbank_q;
        end else begin
          resync_d = 1'b1;
        end
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      resync_q <= 1'b0;
      wbank_q  <= 1'b0;
      busy_q   <= 2'b00;
    end else begin
      cnt_q    <= cnt_d;
      resync_q <= resync_d;
      wbank_q  <= wbank_d;
      busy_q   <= busy_d;
    end
  end

  // header bytes kept aside for decode at frame end
  always_ff @(posedge clk_i) begin
    if (wr && cnt_q == CW'(0)) begin
      cmd_q <= rx_byte_i;
    end
    if (wr && cnt_q == CW'(1)) begin
      hi_q <= rx_byte_i;
    end
    if (wr && cnt_q == CW'(2)) begin
      lo_q <= rx_byte_i;
    end
  end

endmodule

>>> hdl/dcff_back.sv
module dcff_back #(
  parameter int unsigned FRAME_BYTES = dcff_pkg::FRAME_BYTES_DEF,
  localparam int unsigned CW = $clog2(FRAME_BYTES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dcff_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  dcff_pkg::desc_t desc_i,
  output dcff_pkg::rel_t  rel_o,
  output logic [CW:0]     ram_raddr_o,
  input  logic [7:0]      ram_rdata_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      tx_byte_o,
  output logic            last_o,
  output logic            frame_error_o,
  output logic            run_req_o,
  output logic            halt_req_o,
  output logic            ref_update_o,
  output logic [15:0]     ref_compare_o
);
  import dcff_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  localparam logic [CW-1:0] K_LAST = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] K_PAD  = CW'(FRAME_BYTES - 4);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;
  desc_t         desc_q;
  logic [16:0]   diff_q, diff_d;
  logic [32:0]   prod_q, prod_d;
  logic [15:0]   ref_q, ref_d;

  logic [7:0]    tx_q, tx_d;
  logic          last_q, last_d, err_q, err_d;
  logic          st_q, st_d, sp_q, sp_d, upd_q, upd_d;
  logic [15:0]   cmp_q, cmp_d;

  logic          o_free, send_fire, first, k_end;
  logic signed [17:0] dsum;
  logic [16:0]   div_a, div_q;
  logic [17:0]   div_s, ref_v;

  assign o_free    = !out_valid_q || !out_stall_i;
  assign send_fire = (state_q == ST_SEND) && o_free;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign first     = (k_q == CW'(0));
  assign k_end     = (k_q == K_LAST);

  // payload bytes start at frame byte 3
  assign ram_raddr_o = {desc_q.bank, k_q + CW'(3)};

  assign rel_o.valid = send_fire && !desc_q.err && k_end;
  assign rel_o.bank  = desc_q.bank;

  // ref = floor(diff * param / 65535) + compare_start, saturated
  assign dsum   = $signed({2'b00, cfg_i.pwm_period}) + 18'sd1
                - $signed({2'b00, cfg_i.compare_start});
  assign diff_d = dsum[17] ? 17'd0 : dsum[16:0];
  assign prod_d = 33'(diff_q) * 33'(desc_q.param);
  // x = a*65536 + b = a*65535 + (a+b), with a+b < 2*65535
  assign div_a  = prod_q[32:16];
  assign div_s  = {1'b0, div_a} + {2'b00, prod_q[15:0]};
  assign div_q  = div_a + 17'(div_s >= {2'b00, REF_DIV});
  assign ref_v  = {1'b0, div_q} + {2'b00, cfg_i.compare_start};
  assign ref_d  = (ref_v > {2'b00, REF_MAX}) ? REF_MAX : ref_v[15:0];

  always_comb begin
    err_d  = desc_q.err;
    last_d = desc_q.err || k_end;
    tx_d   = 8'd0;
    st_d   = 1'b0;
    sp_d   = 1'b0;
    upd_d  = 1'b0;
    cmp_d  = 16'd0;
    if (!desc_q.err) begin
      if (k_q < K_PAD) begin
        tx_d = ram_rdata_i;
      end else if (k_end) begin
        tx_d = cfg_i.stop_byte;
      end
      if (first) begin
        st_d  = desc_q.st;
        sp_d  = desc_q.sp;
        upd_d = desc_q.upd;
        cmp_d = desc_q.upd ? ref_q : 16'd0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          k_d     = '0;
          state_d = desc_i.err ? ST_SEND : ST_DIFF;
        end
      end
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_FETCH;
      ST_FETCH: state_d = ST_SEND;
      ST_SEND: begin
        if (o_free) begin
          out_valid_d = 1'b1;
          if (desc_q.err || k_end) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= desc_i;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_DIV) begin
      ref_q <= ref_d;
    end
    if (send_fire) begin
      tx_q   <= tx_d;
      last_q <= last_d;
      err_q  <= err_d;
      st_q   <= st_d;
      sp_q   <= sp_d;
      upd_q  <= upd_d;
      cmp_q  <= cmp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_byte_o     = tx_q;
  assign last_o        = last_q;
  assign frame_error_o = err_q;
  assign run_req_o     = st_q;
  assign halt_req_o    = sp_q;
  assign ref_update_o  = upd_q;
  assign ref_compare_o = cmp_q;

endmodule

>>> hdl/daisy_chain_frame_forwarder_unit.sv
// channel | direction | handshake               | payload
// cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
// in      | in        | in_valid_i / in_stall_o | rx_byte_i, motor_state_i
// out     | out       | out_valid_o/out_stall_i | tx_byte_o, last_o, frame_error_o,
//         |           |                         | run_req_o, halt_req_o,
//         |           |                         | ref_update_o, ref_compare_o
// Input bytes are taken one per cycle, while in_stall_o is low, into one of two frame banks.
// A complete frame gives FRAME_BYTES output items: after the pop, ref arithmetic runs in
// DIFF, MUL and DIV, then each item is a frame RAM read (FETCH), then the output register (SEND).
// A rejected frame gives one item, going from the pop straight to SEND.
// Input stalls while both banks wait to be sent or the descriptor queue is full.
// Reset is asynchronous; the frame RAM needs no clearing pass.
module daisy_chain_frame_forwarder_unit #(
  parameter int unsigned FRAME_BYTES = dcff_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dcff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcff_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic signed [7:0]               motor_state_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      tx_byte_o,
  output logic                            last_o,
  output logic                            frame_error_o,
  output logic                            run_req_o,
  output logic                            halt_req_o,
  output logic                            ref_update_o,
  output logic [15:0]                     ref_compare_o
);
  import dcff_pkg::*;

  localparam int unsigned CW = $clog2(FRAME_BYTES);

  cfg_t        cfg_q;
  desc_t       push_desc, pop_desc;
  rel_t        rel;
  logic        push, pop, full, empty;
  logic        ram_we;
  logic [CW:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period    <= 16'd0;
      cfg_q.compare_start <= 16'd0;
      cfg_q.stop_byte     <= STOP_BYTE_RST;
      cfg_q.start_code    <= START_CODE_RST;
      cfg_q.stop_code     <= STOP_CODE_RST;
      cfg_q.set_ref_code  <= SET_REF_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_PERIOD:    cfg_q.pwm_period    <= cfg_wdata_i;
        CFG_COMPARE_START: cfg_q.compare_start <= cfg_wdata_i;
        CFG_STOP_BYTE:     cfg_q.stop_byte     <= cfg_wdata_i[7:0];
        CFG_START_CODE:    cfg_q.start_code    <= cfg_wdata_i[7:0];
        CFG_STOP_CODE:     cfg_q.stop_code     <= cfg_wdata_i[7:0];
        CFG_SET_REF_CODE:  cfg_q.set_ref_code  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  dcff_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .motor_state_i(motor_state_i),
    .push_o       (push),
    .desc_o       (push_desc),
    .full_i       (full),
    .rel_i        (rel),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  dcff_desc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .desc_o (pop_desc)
  );

  dcff_frame_ram #(
    .AW(CW + 1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dcff_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .pop_o        (pop),
    .desc_i       (pop_desc),
    .rel_o        (rel),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o),
    .frame_error_o(frame_error_o),
    .run_req_o    (run_req_o),
    .halt_req_o   (halt_req_o),
    .ref_update_o (ref_update_o),
    .ref_compare_o(ref_compare_o)
  );

endmodule
